@@ hw/rtl/hcb_pkg.sv @@
// Shared constants, command codes and status struct of the Huffman code builder.
// No dependencies; used by hcb_ctrl, hcb_datapath and huffman_code_builder_top.
package hcb_pkg;

  localparam int DefMaxSymbols  = 256;
  localparam int DefMaxCodeBits = 32;
  localparam int SymW           = 8;
  localparam int InFreqW        = 24;
  localparam int FreqW          = 33;
  localparam int NumCodes       = 256;
  localparam int OutCodeW       = 32;
  localparam int OutLenW        = 6;
  localparam int InDataW        = 32;
  localparam int OutDataW       = 40;

  // One datapath operation per cycle, issued by the controller.
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_LOOKUP,
    CMD_START,
    CMD_HFY_RD,
    CMD_HFY_LD,
    CMD_SIFT_RD,
    CMD_SIFT_CMP,
    CMD_TAKE_RD,
    CMD_TAKE_LD_A,
    CMD_TAKE_LD_B,
    CMD_MERGE,
    CMD_PUT_RD,
    CMD_PUT_CMP,
    CMD_PUT_END,
    CMD_ROOT_RD,
    CMD_ROOT_PUSH,
    CMD_POP,
    CMD_NODE_RD,
    CMD_VISIT,
    CMD_PUSH_L
  } cmd_e;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic pend;
    logic cnt_zero;
    logic hi_zero;
    logic size_gt1;
    logic sift_done;
    logic at_zero;
    logic put_up;
    logic sp_zero;
    logic is_leaf;
  } stat_t;

endpackage

@@ hw/rtl/hcb_ctrl.sv @@
// Controller of the Huffman code builder: input handshake and build sequencer.
// Depends on hcb_pkg for cmd_e and stat_t.
module hcb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_kind_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  hcb_pkg::stat_t  stat_i,
  output hcb_pkg::cmd_e   cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_HFY, S_HFY_LD, S_SIFT_RD, S_SIFT_CMP, S_MCHK,
    S_TAKE_RD, S_TAKE_LD, S_MERGE, S_PUT, S_PUT_CMP, S_ROOT_RD, S_ROOT,
    S_POP, S_NODE, S_VISIT, S_PUSHL
  } state_e;

  state_e state_q, ret_q;
  logic   second_q;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.pend;
  assign acc        = in_valid_i && in_ready_o;

  // Map each state to its datapath operation
  always_comb begin
    cmd_o = hcb_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (acc) cmd_o = in_kind_i ? hcb_pkg::CMD_LOOKUP : hcb_pkg::CMD_LOAD;
      end
      S_START:    cmd_o = hcb_pkg::CMD_START;
      S_HFY:      if (!stat_i.hi_zero) cmd_o = hcb_pkg::CMD_HFY_RD;
      S_HFY_LD:   cmd_o = hcb_pkg::CMD_HFY_LD;
      S_SIFT_RD:  cmd_o = hcb_pkg::CMD_SIFT_RD;
      S_SIFT_CMP: cmd_o = hcb_pkg::CMD_SIFT_CMP;
      S_MCHK:     cmd_o = hcb_pkg::CMD_NONE;
      S_TAKE_RD:  cmd_o = hcb_pkg::CMD_TAKE_RD;
      S_TAKE_LD:  cmd_o = second_q ? hcb_pkg::CMD_TAKE_LD_B : hcb_pkg::CMD_TAKE_LD_A;
      S_MERGE:    cmd_o = hcb_pkg::CMD_MERGE;
      S_PUT:      cmd_o = stat_i.at_zero ? hcb_pkg::CMD_PUT_END : hcb_pkg::CMD_PUT_RD;
      S_PUT_CMP:  cmd_o = hcb_pkg::CMD_PUT_CMP;
      S_ROOT_RD:  cmd_o = hcb_pkg::CMD_ROOT_RD;
      S_ROOT:     cmd_o = hcb_pkg::CMD_ROOT_PUSH;
      S_POP:      if (!stat_i.sp_zero) cmd_o = hcb_pkg::CMD_POP;
      S_NODE:     cmd_o = hcb_pkg::CMD_NODE_RD;
      S_VISIT:    cmd_o = hcb_pkg::CMD_VISIT;
      S_PUSHL:    cmd_o = hcb_pkg::CMD_PUSH_L;
      default:    cmd_o = hcb_pkg::CMD_NONE;
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      second_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (acc && !in_kind_i && in_last_i) state_q <= S_START;
        end
        S_START:  state_q <= stat_i.cnt_zero ? S_IDLE : S_HFY;
        S_HFY: begin
          if (stat_i.hi_zero) begin
            state_q <= S_MCHK;
          end else begin
            state_q <= S_HFY_LD;
          end
        end
        S_HFY_LD: begin
          ret_q   <= S_HFY;
          state_q <= S_SIFT_RD;
        end
        S_SIFT_RD:  state_q <= S_SIFT_CMP;
        S_SIFT_CMP: state_q <= stat_i.sift_done ? ret_q : S_SIFT_RD;
        S_MCHK: begin
          second_q <= 1'b0;
          state_q  <= stat_i.size_gt1 ? S_TAKE_RD : S_ROOT_RD;
        end
        S_TAKE_RD:  state_q <= S_TAKE_LD;
        S_TAKE_LD: begin
          ret_q    <= second_q ? S_MERGE : S_TAKE_RD;
          second_q <= !second_q;
          state_q  <= S_SIFT_RD;
        end
        S_MERGE:    state_q <= S_PUT;
        S_PUT:      state_q <= stat_i.at_zero ? S_MCHK : S_PUT_CMP;
        S_PUT_CMP:  state_q <= stat_i.put_up ? S_PUT : S_MCHK;
        S_ROOT_RD:  state_q <= S_ROOT;
        S_ROOT:     state_q <= S_POP;
        S_POP:      state_q <= stat_i.sp_zero ? S_IDLE : S_NODE;
        S_NODE:     state_q <= S_VISIT;
        S_VISIT:    state_q <= stat_i.is_leaf ? S_POP : S_PUSHL;
        S_PUSHL:    state_q <= S_POP;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/hcb_datapath.sv @@
// Datapath of the Huffman code builder: heap, node, stack and code memories,
// sift and walk registers, lookup output register. Depends on hcb_pkg.
module hcb_datapath #(
  parameter int MAX_SYMBOLS   = hcb_pkg::DefMaxSymbols,
  parameter int MAX_CODE_BITS = hcb_pkg::DefMaxCodeBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hcb_pkg::cmd_e                 cmd_i,
  input  logic [hcb_pkg::SymW-1:0]      in_symbol_i,
  input  logic [hcb_pkg::InFreqW-1:0]   in_freq_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [hcb_pkg::OutDataW-1:0]  m_data_o,
  output hcb_pkg::stat_t                stat_o
);

  localparam int HidxW  = $clog2(MAX_SYMBOLS);
  localparam int CntW   = $clog2(MAX_SYMBOLS + 1);
  localparam int NodeW  = $clog2(2 * MAX_SYMBOLS - 1);
  localparam int DepthW = $clog2(MAX_SYMBOLS);
  localparam int LenW   = $clog2(MAX_CODE_BITS + 1);
  localparam int HeW    = hcb_pkg::FreqW + NodeW;
  localparam int KidW   = 2 * NodeW;
  localparam int StkW   = MAX_CODE_BITS + DepthW + NodeW;
  localparam int TblW   = 1 + LenW + MAX_CODE_BITS;
  localparam int ExtW   = HidxW + 2;

  // Memories
  logic [HeW-1:0]               heap_mem [MAX_SYMBOLS];
  logic [hcb_pkg::SymW-1:0]     sym_mem  [MAX_SYMBOLS];
  logic [KidW-1:0]              kid_mem  [MAX_SYMBOLS];
  logic [StkW-1:0]              stk_mem  [MAX_SYMBOLS];
  logic [TblW-1:0]              tbl_mem  [hcb_pkg::NumCodes];

  // Control and work registers
  logic [hcb_pkg::NumCodes-1:0] vld_q;
  logic [CntW-1:0]              cnt_q, size_q, leaves_q, hi_q, sp_q;
  logic [NodeW-1:0]             next_q;
  logic [HidxW-1:0]             at_q;
  logic [HeW-1:0]               cur_q, a_q, b_q, rda_q, rdb_q;
  logic [hcb_pkg::SymW-1:0]     sym_rd_q;
  logic [KidW-1:0]              kid_rd_q;
  logic [StkW-1:0]              stk_rd_q;
  logic [TblW-1:0]              tbl_rd_q;
  logic                         vld_rd_q, pend_q, mv_q;
  logic [hcb_pkg::OutDataW-1:0] mdata_q;

  // Field views
  logic [hcb_pkg::FreqW-1:0] cur_f, rda_f, rdb_f, best_f;
  logic [NodeW-1:0]          stk_node, kid_l, kid_r;
  logic [DepthW-1:0]         stk_depth, depth_inc;
  logic [MAX_CODE_BITS-1:0]  stk_code;

  assign cur_f     = cur_q[HeW-1 -: hcb_pkg::FreqW];
  assign rda_f     = rda_q[HeW-1 -: hcb_pkg::FreqW];
  assign rdb_f     = rdb_q[HeW-1 -: hcb_pkg::FreqW];
  assign stk_node  = stk_rd_q[NodeW-1:0];
  assign stk_depth = stk_rd_q[NodeW +: DepthW];
  assign stk_code  = stk_rd_q[StkW-1 -: MAX_CODE_BITS];
  assign depth_inc = stk_depth + DepthW'(1);
  assign kid_l     = kid_rd_q[KidW-1 -: NodeW];
  assign kid_r     = kid_rd_q[NodeW-1:0];

  // Sift-down child selection
  logic [ExtW-1:0]  l_ext, r_ext;
  logic             l_ok, r_ok, pick_l, pick_r;
  logic [HidxW-1:0] l_addr, r_addr, parent;
  logic             leaf, too_long;

  assign l_ext  = {1'b0, at_q, 1'b0} + ExtW'(1);
  assign r_ext  = {1'b0, at_q, 1'b0} + ExtW'(2);
  assign l_ok   = l_ext < ExtW'(size_q);
  assign r_ok   = r_ext < ExtW'(size_q);
  assign l_addr = l_ext[HidxW-1:0];
  assign r_addr = r_ext[HidxW-1:0];
  assign parent = (at_q - HidxW'(1)) >> 1;

  always_comb begin
    pick_l = l_ok && (rda_f < cur_f);
    best_f = pick_l ? rda_f : cur_f;
    pick_r = r_ok && (rdb_f < best_f);
  end

  assign leaf     = NodeW'(stk_node) < NodeW'(leaves_q);
  assign too_long = int'(stk_depth) > MAX_CODE_BITS;

  // Status to the controller
  always_comb begin
    stat_o.pend      = pend_q;
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.hi_zero   = (hi_q == '0);
    stat_o.size_gt1  = (size_q > CntW'(1));
    stat_o.sift_done = !pick_l && !pick_r;
    stat_o.at_zero   = (at_q == '0);
    stat_o.put_up    = (cur_f < rda_f);
    stat_o.sp_zero   = (sp_q == '0);
    stat_o.is_leaf   = leaf;
  end

  // Memory port selection
  logic             hw_en, ra_en, rb_en, sw_en, sr_en, load_ok;
  logic [HidxW-1:0] hw_addr, ra_addr, rb_addr, sw_addr;
  logic [HeW-1:0]   hw_data;
  logic [StkW-1:0]  sw_data;

  assign load_ok = cnt_q < CntW'(MAX_SYMBOLS);

  always_comb begin
    hw_en = 1'b0; hw_addr = at_q; hw_data = cur_q;
    ra_en = 1'b0; ra_addr = '0;
    rb_en = 1'b0; rb_addr = '0;
    sw_en = 1'b0; sw_addr = sp_q[HidxW-1:0];
    sw_data = {stk_code << 1, depth_inc, kid_l};
    sr_en = 1'b0;
    unique case (cmd_i)
      hcb_pkg::CMD_LOAD: begin
        hw_en   = load_ok;
        hw_addr = cnt_q[HidxW-1:0];
        hw_data = {hcb_pkg::FreqW'(in_freq_i), NodeW'(cnt_q)};
      end
      hcb_pkg::CMD_HFY_RD: begin
        ra_en = 1'b1; ra_addr = HidxW'(hi_q - CntW'(1));
      end
      hcb_pkg::CMD_SIFT_RD: begin
        ra_en = 1'b1; ra_addr = l_addr;
        rb_en = 1'b1; rb_addr = r_addr;
      end
      hcb_pkg::CMD_SIFT_CMP: begin
        hw_en   = 1'b1;
        hw_data = pick_r ? rdb_q : (pick_l ? rda_q : cur_q);
      end
      hcb_pkg::CMD_TAKE_RD: begin
        ra_en = 1'b1; ra_addr = '0;
        rb_en = 1'b1; rb_addr = HidxW'(size_q - CntW'(1));
      end
      hcb_pkg::CMD_PUT_RD: begin
        ra_en = 1'b1; ra_addr = parent;
      end
      hcb_pkg::CMD_PUT_CMP: begin
        hw_en   = 1'b1;
        hw_data = (cur_f < rda_f) ? rda_q : cur_q;
      end
      hcb_pkg::CMD_PUT_END: hw_en = 1'b1;
      hcb_pkg::CMD_ROOT_RD: begin
        ra_en = 1'b1; ra_addr = '0;
      end
      hcb_pkg::CMD_ROOT_PUSH: begin
        sw_en   = 1'b1; sw_addr = '0;
        sw_data = {{MAX_CODE_BITS{1'b0}}, {DepthW{1'b0}}, rda_q[NodeW-1:0]};
      end
      hcb_pkg::CMD_POP: sr_en = 1'b1;
      hcb_pkg::CMD_VISIT: begin
        sw_en   = !leaf;
        sw_data = {(stk_code << 1) | MAX_CODE_BITS'(1), depth_inc, kid_r};
      end
      hcb_pkg::CMD_PUSH_L: sw_en = 1'b1;
      default: ;
    endcase
  end

  // Heap memory, two registered read ports
  always_ff @(posedge clk_i) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    if (ra_en) rda_q <= heap_mem[ra_addr];
    if (rb_en) rdb_q <= heap_mem[rb_addr];
  end

  // Leaf symbols and internal-node children
  always_ff @(posedge clk_i) begin
    if (cmd_i == hcb_pkg::CMD_LOAD && load_ok) sym_mem[cnt_q[HidxW-1:0]] <= in_symbol_i;
    if (cmd_i == hcb_pkg::CMD_MERGE) begin
      kid_mem[HidxW'(next_q - NodeW'(leaves_q))] <= {a_q[NodeW-1:0], b_q[NodeW-1:0]};
    end
    if (cmd_i == hcb_pkg::CMD_NODE_RD) begin
      sym_rd_q <= sym_mem[stk_node[HidxW-1:0]];
      kid_rd_q <= kid_mem[HidxW'(stk_node - NodeW'(leaves_q))];
    end
  end

  // Walk stack
  always_ff @(posedge clk_i) begin
    if (sw_en) stk_mem[sw_addr] <= sw_data;
    if (sr_en) stk_rd_q <= stk_mem[HidxW'(sp_q - CntW'(1))];
  end

  // Code table
  always_ff @(posedge clk_i) begin
    if (cmd_i == hcb_pkg::CMD_VISIT && leaf) begin
      tbl_mem[sym_rd_q] <= too_long ? {1'b1, {(TblW-1){1'b0}}}
                                    : {1'b0, LenW'(stk_depth), stk_code};
    end
    if (cmd_i == hcb_pkg::CMD_LOOKUP) tbl_rd_q <= tbl_mem[in_symbol_i];
  end

  // Output word, fields from bit 0: code, code_length, present, too_long
  always_ff @(posedge clk_i) begin
    if (pend_q && (!mv_q || m_ready_i)) begin
      mdata_q <= vld_rd_q
        ? {tbl_rd_q[TblW-1], 1'b1,
           hcb_pkg::OutLenW'(tbl_rd_q[MAX_CODE_BITS +: LenW]),
           hcb_pkg::OutCodeW'(tbl_rd_q[MAX_CODE_BITS-1:0])}
        : '0;
    end
  end

  assign m_valid_o = mv_q;
  assign m_data_o  = mdata_q;

  // Work registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      hcb_pkg::CMD_START: begin
        leaves_q <= cnt_q;
        size_q   <= cnt_q;
        next_q   <= NodeW'(cnt_q);
        hi_q     <= cnt_q >> 1;
      end
      hcb_pkg::CMD_HFY_LD: begin
        cur_q <= rda_q;
        at_q  <= HidxW'(hi_q - CntW'(1));
        hi_q  <= hi_q - CntW'(1);
      end
      hcb_pkg::CMD_SIFT_CMP: begin
        if (pick_r) begin
          at_q <= r_addr;
        end else if (pick_l) begin
          at_q <= l_addr;
        end
      end
      hcb_pkg::CMD_TAKE_LD_A, hcb_pkg::CMD_TAKE_LD_B: begin
        if (cmd_i == hcb_pkg::CMD_TAKE_LD_A) begin
          a_q <= rda_q;
        end else begin
          b_q <= rda_q;
        end
        cur_q  <= rdb_q;
        size_q <= size_q - CntW'(1);
        at_q   <= '0;
      end
      hcb_pkg::CMD_MERGE: begin
        cur_q  <= {a_q[HeW-1 -: hcb_pkg::FreqW] + b_q[HeW-1 -: hcb_pkg::FreqW], next_q};
        at_q   <= size_q[HidxW-1:0];
        size_q <= size_q + CntW'(1);
        next_q <= next_q + NodeW'(1);
      end
      hcb_pkg::CMD_PUT_CMP: begin
        if (cur_f < rda_f) at_q <= parent;
      end
      default: ;
    endcase
  end

  // Control state: load count, stack pointer, valid bits, output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sp_q     <= '0;
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      pend_q   <= 1'b0;
      mv_q     <= 1'b0;
    end else begin
      unique case (cmd_i)
        hcb_pkg::CMD_LOAD:      if (load_ok) cnt_q <= cnt_q + CntW'(1);
        hcb_pkg::CMD_START: begin
          cnt_q <= '0;
          vld_q <= '0;
        end
        hcb_pkg::CMD_LOOKUP:    vld_rd_q <= vld_q[in_symbol_i];
        hcb_pkg::CMD_ROOT_PUSH: sp_q <= CntW'(1);
        hcb_pkg::CMD_POP:       sp_q <= sp_q - CntW'(1);
        hcb_pkg::CMD_VISIT: begin
          if (leaf) begin
            vld_q[sym_rd_q] <= 1'b1;
          end else begin
            sp_q <= sp_q + CntW'(1);
          end
        end
        hcb_pkg::CMD_PUSH_L:    sp_q <= sp_q + CntW'(1);
        default: ;
      endcase
      // Hand a finished lookup to the output register
      if (pend_q && (!mv_q || m_ready_i)) begin
        mv_q   <= 1'b1;
        pend_q <= 1'b0;
      end else if (mv_q && m_ready_i) begin
        mv_q <= 1'b0;
      end
      if (cmd_i == hcb_pkg::CMD_LOOKUP) pend_q <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/huffman_code_builder_top.sv @@
// Top level of the Huffman code builder: stream ports, controller and datapath.
// Depends on hcb_pkg, hcb_ctrl and hcb_datapath.
//
//  channel  | direction | words
//  s_axis   | in        | load (tuser=0, tlast ends the set) or lookup (tuser=1)
//  m_axis   | out       | one code word per lookup
//
// Loads are taken back to back. A lookup reads the code table, then its word goes to the
// output register; no new word is taken until that register accepts it. The last load starts
// a build: each sift and insert steps through the heap levels (heap memory read, then compare
// and write), then the walk visits each tree node. No word is taken during the build; finished words still drain.
// Reset clears the load count and the valid bits of all code table entries.
module huffman_code_builder_top #(
  parameter int MAX_SYMBOLS   = hcb_pkg::DefMaxSymbols,
  parameter int MAX_CODE_BITS = hcb_pkg::DefMaxCodeBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [hcb_pkg::InDataW-1:0]   s_axis_tdata_i,   // symbol[7:0], freq[31:8]
  input  logic                          s_axis_tuser_i,   // kind
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [hcb_pkg::OutDataW-1:0]  m_axis_tdata_o    // code[31:0], code_length[37:32],
                                                          // present[38], too_long[39]
);

  hcb_pkg::cmd_e  cmd;
  hcb_pkg::stat_t stat;

  hcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hcb_datapath #(
    .MAX_SYMBOLS   (MAX_SYMBOLS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_symbol_i (s_axis_tdata_i[hcb_pkg::SymW-1:0]),
    .in_freq_i   (s_axis_tdata_i[hcb_pkg::SymW +: hcb_pkg::InFreqW]),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o),
    .stat_o      (stat)
  );

endmodule

@@ dv/tb_huffman_code_builder_top.sv @@
// Self-checking testbench of the Huffman code builder: streams load and lookup words,
// predicts every code word with its own tree build and compares field by field.
// Depends on hcb_pkg and the RTL of huffman_code_builder_top.
module tb_huffman_code_builder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Leaves   = hcb_pkg::DefMaxSymbols;
  localparam int Nodes    = 2 * Leaves - 1;
  localparam bit KindLoad = 1'b0;
  localparam bit KindLook = 1'b1;

  typedef struct {
    bit        kind;
    bit [7:0]  sym;
    bit [23:0] freq;
    bit        last;
  } word_t;

  typedef struct {
    bit [31:0] code;
    bit [5:0]  len;
    bit        present;
    bit        too_long;
  } code_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic [hcb_pkg::InDataW-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tready_i = 1'b0;
  logic s_axis_tready_o, m_axis_tvalid_o;
  logic [hcb_pkg::OutDataW-1:0] m_axis_tdata_o;

  huffman_code_builder_top i_dut (.*);

  always #10 clk_i = ~clk_i;

  // Tree builder state
  longint unsigned nd_freq[Nodes];
  int              nd_left[Nodes], nd_right[Nodes], nd_depth[Nodes];
  bit [7:0]        nd_sym[Nodes];
  bit [63:0]       nd_code[Nodes];
  int              heap[Leaves];
  int              stk[Leaves + 1];
  int              leaf_cnt = 0;
  code_word_t      code_tbl[256];

  word_t      pending_q[$];
  code_word_t expected_q[$];
  word_t      cur;
  int         accepted = 0;
  int         total = 0;
  int         errors = 0;
  logic       hold_off = 1'b0;

  function automatic void sift_down(int size, int at);
    int best, l, r, t;
    forever begin
      best = at;
      l = 2 * at + 1;
      r = 2 * at + 2;
      if (l < size && nd_freq[heap[l]] < nd_freq[heap[best]]) best = l;
      if (r < size && nd_freq[heap[r]] < nd_freq[heap[best]]) best = r;
      if (best == at) return;
      t = heap[best];
      heap[best] = heap[at];
      heap[at] = t;
      at = best;
    end
  endfunction

  function automatic int take_min(ref int size);
    int top;
    top = heap[0];
    heap[0] = heap[size - 1];
    size--;
    sift_down(size, 0);
    return top;
  endfunction

  function automatic void put_node(ref int size, input int node);
    int i;
    i = size;
    size++;
    while (i != 0 && nd_freq[node] < nd_freq[heap[(i - 1) / 2]]) begin
      heap[i] = heap[(i - 1) / 2];
      i = (i - 1) / 2;
    end
    heap[i] = node;
  endfunction

  // Merge the two minimums until one root is left, then walk left first
  function automatic void build_codes();
    int n_leaf, size, nxt, sp, a, b, root, n;
    n_leaf = leaf_cnt;
    size = n_leaf;
    nxt = n_leaf;
    sp = 0;
    foreach (code_tbl[s]) code_tbl[s] = '{default: 0};
    leaf_cnt = 0;
    if (n_leaf == 0) return;
    for (int i = 0; i < n_leaf; i++) heap[i] = i;
    for (int i = n_leaf / 2; i > 0; i--) sift_down(size, i - 1);
    while (size > 1) begin
      a = take_min(size);
      b = take_min(size);
      nd_freq[nxt] = nd_freq[a] + nd_freq[b];
      nd_left[nxt] = a;
      nd_right[nxt] = b;
      put_node(size, nxt);
      nxt++;
    end
    root = take_min(size);
    nd_depth[root] = 0;
    nd_code[root] = 0;
    stk[sp++] = root;
    while (sp > 0) begin
      n = stk[--sp];
      if (n < n_leaf) begin
        code_tbl[nd_sym[n]].present = 1'b1;
        if (nd_depth[n] > hcb_pkg::DefMaxCodeBits) begin
          code_tbl[nd_sym[n]].too_long = 1'b1;
          code_tbl[nd_sym[n]].len = '0;
          code_tbl[nd_sym[n]].code = '0;
        end else begin
          code_tbl[nd_sym[n]].too_long = 1'b0;
          code_tbl[nd_sym[n]].len = nd_depth[n][5:0];
          code_tbl[nd_sym[n]].code = nd_code[n][31:0];
        end
      end else begin
        nd_depth[nd_left[n]] = nd_depth[n] + 1;
        nd_depth[nd_right[n]] = nd_depth[n] + 1;
        nd_code[nd_left[n]] = nd_code[n] << 1;
        nd_code[nd_right[n]] = (nd_code[n] << 1) | 64'd1;
        if (sp + 2 <= Leaves + 1) begin
          stk[sp++] = nd_right[n];
          stk[sp++] = nd_left[n];
        end
      end
    end
  endfunction

  // Advance the builder by one accepted word
  function automatic void predict_word(word_t w);
    if (w.kind == KindLoad) begin
      if (leaf_cnt < Leaves) begin
        nd_freq[leaf_cnt] = w.freq;
        nd_sym[leaf_cnt] = w.sym;
        leaf_cnt++;
      end
      if (w.last) build_codes();
    end else begin
      expected_q.insert(expected_q.size(), code_tbl[w.sym]);
    end
  endfunction

  function automatic int sender_idle_pct(int n);
    case ((n / 120) % 4)
      1: return 51;
      3: return 9;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(int n);
    case ((n / 120) % 4)
      2: return 51;
      3: return 9;
      default: return 0;
    endcase
  endfunction

  task automatic add_word(bit kind, bit [7:0] sym, bit [23:0] freq, bit last);
    word_t w;
    w = '{kind, sym, freq, last};
    pending_q.insert(pending_q.size(), w);
    total++;
  endtask

  // Load one set; mode picks the frequency shape
  task automatic add_set(int n, int mode, bit dups, ref bit [7:0] syms[$]);
    bit [7:0] pool[256];
    bit [23:0] f, fa, fb;
    int j;
    bit [7:0] t;
    fa = 1;
    fb = 1;
    syms.delete();
    foreach (pool[i]) pool[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: f = 24'($urandom_range(0, 3));
        1: f = 24'($urandom);
        2: begin
          f = fa;
          fa = fb;
          fb = fb + f;
        end
        default: f = 24'($urandom_range(0, 1000));
      endcase
      t = dups ? 8'($urandom_range(0, 7)) : pool[i % 256];
      syms.insert(syms.size(), t);
      add_word(KindLoad, t, f, i == n - 1);
    end
  endtask

  task automatic add_lookups(int n, bit [7:0] syms[$]);
    for (int i = 0; i < n; i++) begin
      if (syms.size() > 0 && $urandom_range(0, 3) != 0)
        add_word(KindLook, syms[$urandom_range(0, syms.size() - 1)], 24'($urandom),
                 1'($urandom));
      else
        add_word(KindLook, 8'($urandom), 24'($urandom), 1'($urandom));
    end
  endtask

  // Fill the stimulus and wait for the end
  initial begin
    bit [7:0] syms[$];
    bit big_done;
    big_done = 1'b0;
    // lookups before any build, lone symbol, extremes of freq and symbol
    add_word(KindLook, 8'd0, 24'hFFFFFF, 1'b1);
    add_word(KindLook, 8'd255, 24'd0, 1'b0);
    add_word(KindLoad, 8'd77, 24'hFFFFFF, 1'b1);
    add_word(KindLook, 8'd77, 24'd0, 1'b0);
    add_word(KindLook, 8'd78, 24'd0, 1'b0);
    add_word(KindLoad, 8'd0, 24'd0, 1'b0);
    add_word(KindLoad, 8'd255, 24'hFFFFFF, 1'b1);
    add_word(KindLook, 8'd0, 24'd0, 1'b0);
    add_word(KindLook, 8'd255, 24'd0, 1'b0);
    add_word(KindLook, 8'd77, 24'd0, 1'b0);
    // deep tree with codes beyond 32 bits
    add_set(36, 2, 1'b0, syms);
    add_lookups(8, syms);
    // duplicates
    add_set(6, 0, 1'b1, syms);
    add_lookups(6, syms);
    while (total < 900) begin
      if (!big_done && total > 400) begin
        // beyond capacity: 260 loads, the last one still builds
        add_set(260, 1, 1'b0, syms);
        big_done = 1'b1;
      end else begin
        add_set($urandom_range(1, 16), $urandom_range(0, 3), $urandom_range(0, 9) == 0, syms);
      end
      add_lookups($urandom_range(4, 14), syms);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (accepted == total && expected_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hold the receiver off for a long stretch while words keep coming
  initial begin
    wait (accepted >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Driver: predict on accept, then offer the next word or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_word(cur);
        accepted++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct(accepted)) begin
          cur = pending_q.pop_front();
          s_axis_tdata_i <= {cur.freq, cur.sym};
          s_axis_tuser_i <= cur.kind;
          s_axis_tlast_i <= cur.last;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each code word with the oldest expectation
  always @(posedge clk_i) begin
    code_word_t exp_w, got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.code = m_axis_tdata_o[31:0];
        got.len = m_axis_tdata_o[37:32];
        got.present = m_axis_tdata_o[38];
        got.too_long = m_axis_tdata_o[39];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word %h", $realtime, m_axis_tdata_o);
          errors++;
        end else begin
          exp_w = expected_q.pop_front();
          if (got.code !== exp_w.code || got.len !== exp_w.len ||
              got.present !== exp_w.present || got.too_long !== exp_w.too_long) begin
            $display("%0t: mismatch expected code=%h len=%0d present=%b too_long=%b",
                     $realtime, exp_w.code, exp_w.len, exp_w.present, exp_w.too_long);
            $display("%0t:          actual   code=%h len=%0d present=%b too_long=%b",
                     $realtime, got.code, got.len, got.present, got.too_long);
            errors++;
          end
        end
      end
      m_axis_tready_i <= !hold_off && ($urandom_range(0, 99) >= receiver_stall_pct(accepted));
    end
  end

endmodule
